>>> rtl/tos_pkg.sv
// Shared codes, tags and helper functions for the typed operand stack.
package tos_pkg;

    localparam int TosStackBytes = 256;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_RDADDR = 3'd2;
    localparam logic [2:0] OP_RDTOP  = 3'd3;
    localparam logic [2:0] OP_RDSEC  = 3'd4;
    localparam logic [2:0] OP_REMOVE = 3'd5;
    localparam logic [2:0] OP_RESET  = 3'd6;

    localparam logic [1:0] VT_U8   = 2'd0;
    localparam logic [1:0] VT_U32  = 2'd1;
    localparam logic [1:0] VT_I32  = 2'd2;
    localparam logic [1:0] VT_NONE = 2'd3;

    localparam logic [2:0] TAG_NONE     = 3'd0;
    localparam logic [2:0] TAG_U8       = 3'd1;
    localparam logic [2:0] TAG_U32      = 3'd2;
    localparam logic [2:0] TAG_I32      = 3'd3;
    localparam logic [2:0] TAG_U32_BODY = 3'd4;
    localparam logic [2:0] TAG_I32_BODY = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_BADADDR  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_BADTYPE  = 3'd5;

    function automatic logic [2:0] head_tag(input logic [1:0] vt);
        logic [2:0] t;
        unique case (vt)
            VT_U8:   t = TAG_U8;
            VT_U32:  t = TAG_U32;
            default: t = TAG_I32;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] body_tag(input logic [1:0] vt);
        return (vt == VT_U32) ? TAG_U32_BODY : TAG_I32_BODY;
    endfunction

    function automatic logic [1:0] tag_type(input logic [2:0] t);
        logic [1:0] v;
        unique case (t)
            TAG_U8:  v = VT_U8;
            TAG_U32: v = VT_U32;
            TAG_I32: v = VT_I32;
            default: v = VT_NONE;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] tag_size(input logic [2:0] t);
        logic [2:0] s;
        unique case (t)
            TAG_U8:           s = 3'd1;
            TAG_U32, TAG_I32: s = 3'd4;
            default:          s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic tag_is_body(input logic [2:0] t);
        return (t == TAG_U32_BODY) || (t == TAG_I32_BODY);
    endfunction

endpackage

>>> rtl/typed_operand_stack.sv
// Typed operand stack: one byte-wide tagged memory and a read-modify-write sequencer.
// Reset, unused codes and early failures raise done the cycle after accept; push
// writes in S_PUSHW, reads and pop go S_HEAD/S_BODY, remove loops S_REMOVE/S_DROP.
// One memory port pair sets the pace: one byte read and one byte written a cycle.
// Busy is high while an operation runs; done strobes one cycle and cannot be held.
// Reset (and the reset op) clears top and count at once; memory holds no reset value.
module typed_operand_stack #(
    parameter int STACK_BYTES = tos_pkg::TosStackBytes
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          op,
    input  logic [1:0]                          value_type,
    input  logic [31:0]                         push_value,
    input  logic [7:0]                          byte_addr,
    input  logic [7:0]                          remove_count,
    output logic                                done,
    output logic [31:0]                         data,
    output logic [1:0]                          data_type,
    output logic [2:0]                          status,
    output logic [$clog2(STACK_BYTES+1)-1:0]    entry_count
);
    import tos_pkg::*;

    localparam int AW = $clog2(STACK_BYTES);
    localparam int CW = $clog2(STACK_BYTES + 1);
    localparam int XW = ((AW > 8) ? AW : 8) + 2;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PTAG   = 3'd1;
    localparam logic [2:0] S_PUSHW  = 3'd2;
    localparam logic [2:0] S_HEAD   = 3'd3;
    localparam logic [2:0] S_BODY   = 3'd4;
    localparam logic [2:0] S_PREV   = 3'd5;
    localparam logic [2:0] S_DROP   = 3'd6;
    localparam logic [2:0] S_REMOVE = 3'd7;

    // {tag, byte}; only entries below top plus the top entry are ever read,
    // and all of those were written by a push since the last reset
    logic [10:0] stack_mem [STACK_BYTES];

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] top_reg, top_next;
    logic [CW-1:0] ent_reg, ent_next;
    logic          done_reg, done_next;
    logic [2:0]    op_reg, op_next;
    logic [1:0]    vt_reg, vt_next;
    logic [31:0]   val_reg, val_next;
    logic [7:0]    cnt_reg, cnt_next;
    logic [AW-1:0] base_reg, base_next;
    logic [AW-1:0] at_reg, at_next;
    logic [1:0]    k_reg, k_next;
    logic [31:0]   data_reg, data_next;
    logic [1:0]    dtype_reg, dtype_next;
    logic [2:0]    status_reg, status_next;
    logic [10:0]   rdata_reg;

    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [10:0]   wr_data;

    logic [2:0]    rtag;
    logic [AW-1:0] below;
    logic [AW-1:0] prev_start;
    logic [XW-1:0] push_at;
    logic [XW-1:0] push_end;
    logic [XW-1:0] addr_x;
    logic          push_last;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= stack_mem[rd_addr];
    end

    assign rtag  = rdata_reg[10:8];
    assign below = top_reg - AW'(1);
    assign prev_start = tag_is_body(rtag) ? ((below >= AW'(3)) ? below - AW'(3) : '0) : below;
    assign push_at  = XW'(top_reg) + XW'(tag_size(rtag));
    assign push_end = push_at + ((vt_reg == VT_U8) ? XW'(1) : XW'(4));
    assign addr_x   = XW'(byte_addr);
    assign push_last = (vt_reg == VT_U8) ? (k_reg == 2'd0) : (k_reg == 2'd3);

    always_comb
    begin
        state_next  = state_reg;
        top_next    = top_reg;
        ent_next    = ent_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        vt_next     = vt_reg;
        val_next    = val_reg;
        cnt_next    = cnt_reg;
        base_next   = base_reg;
        at_next     = at_reg;
        k_next      = k_reg;
        data_next   = data_reg;
        dtype_next  = dtype_reg;
        status_next = status_reg;
        rd_addr     = top_reg;
        we          = 1'b0;
        wr_addr     = at_reg + AW'(k_reg);
        wr_data     = {(k_reg == 2'd0) ? head_tag(vt_reg) : body_tag(vt_reg),
                       val_reg[8*k_reg +: 8]};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = op;
                    vt_next     = value_type;
                    val_next    = push_value;
                    cnt_next    = remove_count;
                    data_next   = '0;
                    dtype_next  = VT_NONE;
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    unique case (op)
                        OP_PUSH:
                        begin
                            if (value_type == VT_NONE)
                            begin
                                status_next = ST_BADTYPE;
                            end
                            else if (ent_reg == '0)
                            begin
                                at_next    = '0;
                                k_next     = 2'd0;
                                done_next  = 1'b0;
                                state_next = S_PUSHW;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = S_PTAG;
                            end
                        end
                        OP_POP:
                        begin
                            if (value_type == VT_NONE)
                            begin
                                status_next = ST_BADTYPE;
                            end
                            else if (ent_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                base_next  = top_reg;
                                done_next  = 1'b0;
                                state_next = S_HEAD;
                            end
                        end
                        OP_RDADDR:
                        begin
                            if (value_type == VT_NONE)
                            begin
                                status_next = ST_BADTYPE;
                            end
                            else if (addr_x >= XW'(STACK_BYTES) || addr_x > XW'(top_reg))
                            begin
                                status_next = ST_BADADDR;
                            end
                            else if (ent_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = AW'(byte_addr);
                                base_next  = AW'(byte_addr);
                                done_next  = 1'b0;
                                state_next = S_HEAD;
                            end
                        end
                        OP_RDTOP:
                        begin
                            if (ent_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                base_next  = top_reg;
                                done_next  = 1'b0;
                                state_next = S_HEAD;
                            end
                        end
                        OP_RDSEC:
                        begin
                            if (ent_reg < CW'(2))
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = below;
                                done_next  = 1'b0;
                                state_next = S_PREV;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (ent_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = S_REMOVE;
                            end
                        end
                        OP_RESET:
                        begin
                            top_next = '0;
                            ent_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_PTAG:
            begin
                if (push_end > XW'(STACK_BYTES))
                begin
                    status_next = ST_OVERFLOW;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    at_next    = push_at[AW-1:0];
                    k_next     = 2'd0;
                    state_next = S_PUSHW;
                end
            end
            S_PUSHW:
            begin
                we = 1'b1;
                if (push_last)
                begin
                    top_next   = at_reg;
                    ent_next   = ent_reg + CW'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_HEAD:
            begin
                data_next[7:0] = rdata_reg[7:0];
                if ((op_reg == OP_POP || op_reg == OP_RDADDR) && rtag != head_tag(vt_reg))
                begin
                    status_next = ST_MISMATCH;
                    data_next   = '0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    dtype_next = (op_reg == OP_POP || op_reg == OP_RDADDR) ? vt_reg
                                                                            : tag_type(rtag);
                    if (tag_size(rtag) == 3'd4)
                    begin
                        rd_addr    = base_reg + AW'(1);
                        k_next     = 2'd1;
                        state_next = S_BODY;
                    end
                    else if (op_reg == OP_POP)
                    begin
                        ent_next = ent_reg - CW'(1);
                        if (ent_reg == CW'(1))
                        begin
                            top_next   = '0;
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            rd_addr    = below;
                            state_next = S_DROP;
                        end
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_BODY:
            begin
                data_next[8*k_reg +: 8] = rdata_reg[7:0];
                if (k_reg != 2'd3)
                begin
                    rd_addr = base_reg + AW'(k_reg) + AW'(1);
                    k_next  = k_reg + 2'd1;
                end
                else if (op_reg == OP_POP)
                begin
                    ent_next = ent_reg - CW'(1);
                    if (ent_reg == CW'(1))
                    begin
                        top_next   = '0;
                        done_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_addr    = below;
                        state_next = S_DROP;
                    end
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_PREV:
            begin
                rd_addr    = prev_start;
                base_next  = prev_start;
                state_next = S_HEAD;
            end
            S_DROP:
            begin
                top_next = prev_start;
                if (op_reg == OP_POP)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_REMOVE;
                end
            end
            S_REMOVE:
            begin
                if (cnt_reg == 8'd0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (ent_reg == '0)
                begin
                    status_next = ST_EMPTY;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 8'd1;
                    ent_next = ent_reg - CW'(1);
                    if (ent_reg == CW'(1))
                    begin
                        top_next = '0;
                    end
                    else
                    begin
                        rd_addr    = below;
                        state_next = S_DROP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            top_reg   <= '0;
            ent_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            ent_reg   <= ent_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        vt_reg     <= vt_next;
        val_reg    <= val_next;
        cnt_reg    <= cnt_next;
        base_reg   <= base_next;
        at_reg     <= at_next;
        k_reg      <= k_next;
        data_reg   <= data_next;
        dtype_reg  <= dtype_next;
        status_reg <= status_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign data        = data_reg;
    assign data_type   = dtype_reg;
    assign status      = status_reg;
    assign entry_count = ent_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ent_reg <= CW'(STACK_BYTES))
        else $error("entry count beyond capacity");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == ST_MISMATCH || status == ST_BADADDR ||
                 status == ST_OVERFLOW || status == ST_BADTYPE)
        |-> (data == 32'd0 && data_type == VT_NONE))
        else $error("failed transfer carries data");

    a_start_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transfer dropped");

endmodule
